// ----- rtl/woc_pkg.sv -----
package woc_pkg;

    localparam int SCORE_W   = 17;
    localparam int ALPHA_W   = 12;
    localparam int LEVEL_W   = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;
    localparam int VAR_W     = 32;
    localparam int STD_W     = VAR_W / 2;
    localparam int FRAC_W    = 8;
    localparam int DEV_W     = ALPHA_W + STD_W;
    localparam int CMP_W     = DEV_W + 1;

    localparam logic [SCORE_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [SCORE_W-1:0] HI_FLOOR = 17'd64881;
    localparam logic [SCORE_W-1:0] LO_CEIL  = 17'd655;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 12'd256;

    localparam logic [LEVEL_W-1:0] LEVEL_NORMAL = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH   = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_VDIV,
        ST_SQRT,
        ST_DEV,
        ST_PUSH,
        ST_OUT
    } woc_state_t;

endpackage

// ----- rtl/windowed_outlier_classifier.sv -----
// Classifies each nonzero similarity score (unsigned Q1.16, values above 1.0 saturate) as
// normal, high or low against the mean and population standard deviation of up to WINDOW
// earlier nonzero scores, then stores it in the window in place of the oldest. A zero score
// leaves the window alone and goes from IDLE straight to OUT, where its normal result is
// loaded. The first nonzero score after reset skips the statistics, goes through DEV, PUSH
// and OUT and returns normal. Any other score passes through MUL, VDIV, SQRT, DEV, PUSH, OUT.
// The mean divide and the two sum products run one bit per cycle, the mean divide and the
// S*S product over SW bits and the n*Q product over the NB bits of the fill count. The
// variance divide produces 32 quotient bits, one per cycle. The square root produces 16
// root bits, one per cycle. DEV forms the deviation product, PUSH updates the window and
// OUT loads the output. The input is ready again on the cycle after the result is loaded.
// One score is worked on at a time. A finished level sits in the output register, so the
// next score can be taken while it waits. A level that finishes while the previous one is
// still waiting holds until that one is taken. alpha_gain (unsigned Q4.8, reset 1.0) scales
// the deviation and may only be written while the block is idle.
module windowed_outlier_classifier #(
    parameter int WINDOW = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [woc_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // [16:0] ssi_value
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [woc_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // [1:0] level
    input  logic                             cfg_we,
    input  logic [woc_pkg::ALPHA_W-1:0]      cfg_wdata       // alpha_gain
);

    import woc_pkg::*;

    localparam int LW  = $clog2(WINDOW);
    localparam int NB  = $clog2(WINDOW + 1);
    localparam int SW  = SCORE_W + LW;
    localparam int QSW = 2 * SCORE_W - 1 + LW;
    localparam int VNW = 2 * SW;
    localparam int SQW = 2 * SCORE_W;

    woc_state_t state_reg, state_next;

    logic [ALPHA_W-1:0] alpha_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               classify_reg;
    logic [LW-1:0]      wp_reg;
    logic [NB-1:0]      fill_reg;
    logic [SW-1:0]      sum_reg;
    logic [QSW-1:0]     sq_reg;
    logic [2*NB-1:0]    nsq_reg;
    logic [DEV_W-1:0]   dev_reg;
    logic [SQW-1:0]     oldsq_reg;
    logic [SQW-1:0]     newsq_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic [LEVEL_W-1:0] m_level_reg;
    logic               m_valid_reg;

    logic               s_fire;
    logic [SCORE_W-1:0] score_in;
    logic               start_stats;
    logic               start_vdiv;
    logic               start_sqrt;
    logic               ram_we;
    logic               out_load;

    logic               mean_busy, nq_busy, ss_busy, vdiv_busy, sqrt_busy;
    logic [SW-1:0]      mean_q;
    logic [QSW+NB-1:0]  nq_prod;
    logic [2*SW-1:0]    ss_prod;
    logic [VNW-1:0]     nq_ext;
    logic [VNW-1:0]     var_num;
    logic [VAR_W-1:0]   var_q;
    logic [STD_W-1:0]   std_w;
    logic [SCORE_W-1:0] mean_w;
    logic [SCORE_W-1:0] old_w;
    logic               full;
    logic               high_hit, low_hit;
    logic [CMP_W-1:0]   lhs_c, mean_c, dev_c;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign score_in = (s_axis_tdata[SCORE_W-1:0] > ONE_Q16) ? ONE_Q16
                                                              : s_axis_tdata[SCORE_W-1:0];
    assign full     = (fill_reg == NB'(WINDOW));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (score_in == '0) begin
                        state_next = ST_OUT;
                    end else if (fill_reg == '0) begin
                        state_next = ST_DEV;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (!mean_busy && !nq_busy && !ss_busy) begin
                    state_next = ST_VDIV;
                end
            end
            ST_VDIV: begin
                if (!vdiv_busy) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (!sqrt_busy) begin
                    state_next = ST_DEV;
                end
            end
            ST_DEV:  state_next = ST_PUSH;
            ST_PUSH: state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        start_vdiv    = 1'b0;
        start_sqrt    = 1'b0;
        ram_we        = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_MUL:  start_vdiv    = !mean_busy && !nq_busy && !ss_busy;
            ST_VDIV: start_sqrt    = !vdiv_busy;
            ST_SQRT: ;
            ST_DEV:  ;
            ST_PUSH: ram_we        = 1'b1;
            ST_OUT:  out_load      = !m_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    assign start_stats = s_fire && (score_in != '0) && (fill_reg != '0);

    woc_serial_div #(.NW(SW), .DW(NB), .QW(SW)) u_mean_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_stats),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .busy     (mean_busy),
        .quotient (mean_q)
    );

    woc_serial_mul #(.AW(QSW), .BW(NB)) u_nq_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_stats),
        .a       (sq_reg),
        .b       (fill_reg),
        .busy    (nq_busy),
        .product (nq_prod)
    );

    woc_serial_mul #(.AW(SW), .BW(SW)) u_ss_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_stats),
        .a       (sum_reg),
        .b       (sum_reg),
        .busy    (ss_busy),
        .product (ss_prod)
    );

    // n*Q - S*S, clamped at zero
    assign nq_ext  = VNW'(nq_prod);
    assign var_num = (nq_ext > ss_prod) ? (nq_ext - ss_prod) : '0;

    woc_serial_div #(.NW(VNW), .DW(2 * NB), .QW(VAR_W)) u_var_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_vdiv),
        .dividend (var_num),
        .divisor  (nsq_reg),
        .busy     (vdiv_busy),
        .quotient (var_q)
    );

    woc_isqrt #(.XW(VAR_W)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_sqrt),
        .radicand (var_q),
        .busy     (sqrt_busy),
        .root     (std_w)
    );

    woc_ram #(.WIDTH(SCORE_W), .DEPTH(WINDOW)) u_history (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (score_reg),
        .rd_en   (s_fire),
        .rd_addr (wp_reg),
        .rd_data (old_w)
    );

    assign mean_w = mean_q[SCORE_W-1:0];

    // thresholds compared in Q.24
    assign lhs_c  = CMP_W'({score_reg, {FRAC_W{1'b0}}});
    assign mean_c = CMP_W'({mean_w, {FRAC_W{1'b0}}});
    assign dev_c  = CMP_W'(dev_reg);

    assign high_hit = (lhs_c >= mean_c + dev_c)
                   || (((SCORE_W + 1)'(mean_w) + (SCORE_W + 1)'(std_w)
                        >= (SCORE_W + 1)'(ONE_Q16)) && (score_reg >= HI_FLOOR));
    assign low_hit  = (lhs_c + dev_c < mean_c)
                   || ((mean_w <= SCORE_W'(std_w)) && (score_reg <= LO_CEIL));

    always_comb begin
        level_next = LEVEL_NORMAL;
        if (classify_reg && (mean_w != '0) && (std_w != '0)) begin
            if (high_hit) begin
                level_next = LEVEL_HIGH;
            end else if (low_hit) begin
                level_next = LEVEL_LOW;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            alpha_reg   <= ALPHA_RESET;
            wp_reg      <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                alpha_reg <= cfg_wdata;
            end
            if (ram_we) begin
                wp_reg <= (wp_reg == LW'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                if (full) begin
                    sum_reg <= sum_reg - SW'(old_w) + SW'(score_reg);
                    sq_reg  <= sq_reg - QSW'(oldsq_reg) + QSW'(newsq_reg);
                end else begin
                    fill_reg <= fill_reg + 1'b1;
                    sum_reg  <= sum_reg + SW'(score_reg);
                    sq_reg   <= sq_reg + QSW'(newsq_reg);
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            score_reg    <= score_in;
            classify_reg <= (fill_reg != '0);
            nsq_reg      <= (2 * NB)'(fill_reg) * (2 * NB)'(fill_reg);
            level_reg    <= LEVEL_NORMAL;
        end
        if (state_reg == ST_DEV) begin
            dev_reg   <= DEV_W'(alpha_reg) * DEV_W'(std_w);
            oldsq_reg <= SQW'(old_w) * SQW'(old_w);
            newsq_reg <= SQW'(score_reg) * SQW'(score_reg);
        end
        if (ram_we) begin
            level_reg <= level_next;
        end
        if (out_load) begin
            m_level_reg <= level_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(m_level_reg);

endmodule

// ----- rtl/woc_ram.sv -----
module woc_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/woc_serial_mul.sv -----
module woc_serial_mul #(
    parameter int AW = 21,
    parameter int BW = 21
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             busy,
    output logic [AW+BW-1:0] product
);

    localparam int CW = (BW > 1) ? $clog2(BW) : 1;

    logic [AW-1:0] a_reg;
    logic [AW-1:0] hi_reg;
    logic [BW-1:0] lo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [AW:0]   sum;

    // one multiplier bit per cycle, lsb first, product shifts right
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(BW - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= sum[AW:1];
            lo_reg <= {sum[0], lo_reg[BW-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ----- rtl/woc_serial_div.sv -----
module woc_serial_div #(
    parameter int NW = 21,
    parameter int DW = 5,
    parameter int QW = 21
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [QW-1:0] quotient
);

    localparam int CW = (QW > 1) ? $clog2(QW) : 1;

    logic [DW-1:0]    rem_reg;
    logic [NW-1:0]    num_reg;
    logic [DW-1:0]    den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [DW+NW-1:0] init_w;
    logic [DW:0]      sh;
    logic [DW:0]      diff;
    logic             ge;

    // high dividend bits above the quotient go straight into the remainder
    assign init_w = {{DW{1'b0}}, dividend} << (NW - QW);
    assign sh     = {rem_reg, num_reg[NW-1]};
    assign diff   = sh - {1'b0, den_reg};
    assign ge     = (sh >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(QW - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            {rem_reg, num_reg} <= init_w;
            den_reg            <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DW-1:0] : sh[DW-1:0];
            num_reg <= {num_reg[NW-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = num_reg[QW-1:0];

endmodule

// ----- rtl/woc_isqrt.sv -----
module woc_isqrt #(
    parameter int XW = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [XW-1:0]     radicand,
    output logic              busy,
    output logic [XW/2-1:0]   root
);

    localparam int RW = XW / 2;
    localparam int CW = (RW > 1) ? $clog2(RW) : 1;

    logic [XW-1:0] x_reg;
    logic [RW:0]   rem_reg;
    logic [RW-1:0] root_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [RW+2:0] r2;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    // one root bit per cycle from two radicand bits
    assign r2    = {rem_reg, x_reg[XW-1:XW-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign diff  = r2 - trial;
    assign ge    = (r2 >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(RW - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[XW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW:0] : r2[RW:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ----- tb/sv/windowed_outlier_classifier_tb.sv -----
module windowed_outlier_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import woc_pkg::*;

    localparam int WINDOW_DEPTH = 16;

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;   // [16:0] ssi_value
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;         // [1:0] level
    logic                   cfg_we        = 1'b0;
    logic [ALPHA_W-1:0]     cfg_wdata     = '0;

    windowed_outlier_classifier #(
        .WINDOW(WINDOW_DEPTH)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // mirror of the score window
    logic [SCORE_W-1:0]     win_hist [WINDOW_DEPTH];
    int unsigned            win_wr_ptr   = 0;
    int unsigned            win_fill     = 0;
    logic [63:0]            win_sum      = '0;
    logic [63:0]            win_sq_sum   = '0;
    logic [ALPHA_W-1:0]     alpha_gain_q = ALPHA_RESET;

    logic [LEVEL_W-1:0]     level_expect_q [$];
    int unsigned            fail_count = 0;
    int unsigned            burst_left = 0;

    int unsigned            stall_mode = 0;
    int unsigned            stall_left = 0;
    logic [LEVEL_W-1:0]     level_want;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(10_000_000);
        $display("windowed_outlier_classifier verification failed");
        $finish;
    end

    function automatic logic [63:0] isqrt_floor(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) root = trial;
        end
        return root;
    endfunction

    // classify against the window as it stands, then store the score
    function automatic logic [LEVEL_W-1:0] classify_and_store(input logic [SCORE_W-1:0] raw);
        logic [63:0]        score;
        logic [63:0]        n;
        logic [63:0]        mean;
        logic [63:0]        var_q32;
        logic [63:0]        std_q16;
        logic [63:0]        dev;
        logic [63:0]        n_sq_sum;
        logic [63:0]        sum_sq;
        logic [63:0]        old;
        logic [LEVEL_W-1:0] lvl;
        score   = (raw > ONE_Q16) ? 64'(ONE_Q16) : 64'(raw);
        lvl     = LEVEL_NORMAL;
        mean    = '0;
        std_q16 = '0;
        if (score == 0) return LEVEL_NORMAL;
        n = 64'(win_fill);
        if (n != 0) begin
            mean     = win_sum / n;
            n_sq_sum = n * win_sq_sum;
            sum_sq   = win_sum * win_sum;
            var_q32  = (n_sq_sum > sum_sq) ? (n_sq_sum - sum_sq) / (n * n) : 64'd0;
            std_q16  = isqrt_floor(var_q32);
        end
        if (win_fill == WINDOW_DEPTH) begin
            old        = 64'(win_hist[win_wr_ptr]);
            win_sum    = win_sum - old;
            win_sq_sum = win_sq_sum - old * old;
        end else begin
            win_fill++;
        end
        win_hist[win_wr_ptr] = score[SCORE_W-1:0];
        win_sum    = win_sum + score;
        win_sq_sum = win_sq_sum + score * score;
        win_wr_ptr = (win_wr_ptr + 1) % WINDOW_DEPTH;
        if (n != 0 && mean != 0 && std_q16 != 0) begin
            dev = 64'(alpha_gain_q) * std_q16;
            if ((score << 8) >= (mean << 8) + dev ||
                (mean + std_q16 >= ONE_Q16 && score >= HI_FLOOR))
                lvl = LEVEL_HIGH;
            else if ((score << 8) + dev < (mean << 8) ||
                     (mean <= std_q16 && score <= LO_CEIL))
                lvl = LEVEL_LOW;
        end
        return lvl;
    endfunction

    task automatic send_score(input logic [SCORE_W-1:0] value);
        int unsigned        gap;
        logic [LEVEL_W-1:0] lvl;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-SCORE_W){1'b0}}, value};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        lvl = classify_and_store(value);
        level_expect_q = {level_expect_q, lvl};
        burst_left--;
    endtask

    task automatic close_burst();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_results_drained();
        close_burst();
        while (level_expect_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_alpha(input logic [ALPHA_W-1:0] gain);
        wait_results_drained();
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= gain;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        alpha_gain_q = gain;
    endtask

    function automatic logic [SCORE_W-1:0] pick_score(input int unsigned center,
                                                      input int unsigned spread);
        int unsigned roll;
        int          v;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 10) return SCORE_W'($urandom_range(65537, 131071));
        if (roll < 16) begin
            case ($urandom_range(0, 7))
                0: return SCORE_W'(1);
                1: return LO_CEIL;
                2: return SCORE_W'(LO_CEIL + 1);
                3: return SCORE_W'(HI_FLOOR - 1);
                4: return HI_FLOOR;
                5: return SCORE_W'(ONE_Q16 - 1);
                6: return ONE_Q16;
                default: return '1;
            endcase
        end
        if (roll < 26) return SCORE_W'($urandom_range(1, 65536));
        v = int'(center) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (v < 1) v = 1;
        if (v > 65536) v = 65536;
        return SCORE_W'(v);
    endfunction

    // empty window, saturation, zero deviation and plain edge values at reset gain
    task automatic test_edge_scores();
        send_score('0);
        send_score('1);
        send_score(ONE_Q16);
        send_score(SCORE_W'(ONE_Q16 + 1));
        send_score(SCORE_W'(1));
        send_score(SCORE_W'(32768));
        send_score(LO_CEIL);
        send_score(HI_FLOOR);
        send_score('0);
    endtask

    // window near full scale, huge gain: only the 0.99 rule can flag high
    task automatic test_high_floor();
        set_alpha('1);
        repeat (5) send_score(ONE_Q16);
        send_score(SCORE_W'(40000));
        send_score(HI_FLOOR);
        send_score(SCORE_W'(HI_FLOOR - 1));
    endtask

    // mean pulled under std with tiny scores: only the 0.01 rule can flag low
    task automatic test_low_floor();
        repeat (6) send_score(SCORE_W'(1));
        send_score(LO_CEIL);
        send_score(SCORE_W'(LO_CEIL + 1));
    endtask

    task automatic test_random_window(input logic [ALPHA_W-1:0] gain,
                                      input int unsigned center,
                                      input int unsigned spread,
                                      input int unsigned count);
        set_alpha(gain);
        for (int unsigned i = 0; i < count; i++) begin
            send_score(pick_score(center, spread));
            // sender holds off until the block has nothing outstanding
            if (i == count / 2) wait_results_drained();
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (level_expect_q.size() == 0) begin
                $error("level: unexpected transfer, got %0d", m_axis_tdata[LEVEL_W-1:0]);
                fail_count++;
            end else begin
                level_want = level_expect_q.pop_front();
                if (m_axis_tdata[LEVEL_W-1:0] !== level_want) begin
                    $error("level mismatch: expected %0d, got %0d",
                           level_want, m_axis_tdata[LEVEL_W-1:0]);
                    fail_count++;
                end
            end
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 150);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edge_scores();
        test_high_floor();
        test_low_floor();
        test_random_window(ALPHA_RESET, 32768, 2000, 265);
        test_random_window('0, 20000, 20000, 265);
        test_random_window('1, 65200, 500, 265);
        test_random_window(ALPHA_W'($urandom_range(1, 4095)), 400, 500, 265);
        test_random_window(ALPHA_W'($urandom_range(1, 4095)),
                           $urandom_range(1, 65536), $urandom_range(1, 30000), 265);

        wait_results_drained();
        repeat (80) @(posedge aclk);
        if (fail_count == 0) begin
            $display("windowed_outlier_classifier verification clean");
        end else begin
            $display("windowed_outlier_classifier verification failed");
        end
        $finish;
    end

endmodule
